// ===== rtl/swsort_pkg.sv =====
// Shared types and constants of the signed word sorter.
package swsort_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT_DOWN,
        OP_SHIFT_UP
    } cell_op_t;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic                      valid;
        logic                      gt;
        logic signed [VALUE_W-1:0] value;
    } cell_link_t;

endpackage

// ===== rtl/swsort_cell.sv =====
// One cell of the sorting chain: holds a single element and its valid bit.
module swsort_cell (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  swsort_pkg::cell_op_t               op,
    input  logic signed [swsort_pkg::VALUE_W-1:0] x,
    input  swsort_pkg::cell_link_t             left_in,
    input  swsort_pkg::cell_link_t             right_in,
    output swsort_pkg::cell_link_t             link_out
);
    import swsort_pkg::*;

    logic                      valid_reg, valid_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      gt;
    logic                      take_prev;
    logic                      place_here;

    // This cell holds a value strictly greater than the arriving one.
    assign gt = valid_reg && (value_reg > x);

    // The left neighbor moves up into this cell when it is also greater.
    assign take_prev  = left_in.gt;
    assign place_here = !take_prev && (gt || (!valid_reg && left_in.valid));

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        unique case (op)
            OP_INSERT: begin
                if (take_prev) begin
                    valid_next = 1'b1;
                    value_next = left_in.value;
                end else if (place_here) begin
                    valid_next = 1'b1;
                    value_next = x;
                end
            end
            OP_SHIFT_DOWN: begin
                valid_next = right_in.valid;
                value_next = right_in.value;
            end
            OP_SHIFT_UP: begin
                valid_next = left_in.valid;
                value_next = left_in.value;
            end
            default: begin
                valid_next = valid_reg;
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
    end

    assign link_out.valid = valid_reg;
    assign link_out.gt    = gt;
    assign link_out.value = value_reg;

endmodule

// ===== rtl/swsort_chain.sv =====
// Row of sorting cells, kept in ascending order from cell 0 upward.
module swsort_chain #(
    parameter int CAPACITY = swsort_pkg::CAPACITY_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  swsort_pkg::cell_op_t               op,
    input  logic signed [swsort_pkg::VALUE_W-1:0] x,
    output swsort_pkg::cell_link_t             bottom,
    output swsort_pkg::cell_link_t             top
);
    import swsort_pkg::*;

    cell_link_t lnk [CAPACITY];
    cell_link_t low_edge;
    cell_link_t high_edge;

    // Below cell 0 sits a filled slot that is never greater during an insert,
    // and an empty slot while the row shifts upward.
    assign low_edge.valid  = (op == OP_INSERT);
    assign low_edge.gt     = 1'b0;
    assign low_edge.value  = '0;
    assign high_edge.valid = 1'b0;
    assign high_edge.gt    = 1'b0;
    assign high_edge.value = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        cell_link_t left_in;
        cell_link_t right_in;
        if (i == 0) begin : g_lo
            assign left_in = low_edge;
        end else begin : g_lo_n
            assign left_in = lnk[i-1];
        end
        if (i == CAPACITY - 1) begin : g_hi
            assign right_in = high_edge;
        end else begin : g_hi_n
            assign right_in = lnk[i+1];
        end
        swsort_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .op       (op),
            .x        (x),
            .left_in  (left_in),
            .right_in (right_in),
            .link_out (lnk[i])
        );
    end

    assign bottom = lnk[0];
    assign top    = lnk[CAPACITY-1];

endmodule

// ===== rtl/signed_word_sorter.sv =====
// Top level of the signed word sorter: insertion chain, control and stream ports.
//
// The sorter collects a set of signed 32-bit values, one per input transfer,
// and emits them sorted once the transfer with s_tlast set has arrived. Each
// arriving value is placed by a row of CAPACITY cells that all compare
// against it in parallel and shift the larger ones up by one place, so a set
// loads at one transfer per clock. After the final transfer the block stops
// taking input and drains the row: smallest first when the ascending bit was
// 1 at the final transfer, largest first when it was 0. An ascending burst
// hands out a stored element each time the row shifts; a descending burst
// shifts the row toward its top end, so its first result waits until the
// values have travelled past the empty cells. Both bursts stall while a
// result waits untaken and m_tready is low. The final result carries m_tlast,
// and m_tuser is 1 on every result of a set that lost values because the row
// was full. Input is taken again in the cycle after the last result enters the
// output register, while that result may still wait there to be taken.
module signed_word_sorter #(
    parameter int CAPACITY = swsort_pkg::CAPACITY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: bit 0 is the ascending register.
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [swsort_pkg::VALUE_W-1:0]    s_tdata,   // [31:0] value
    input  logic                              s_tlast,   // final_item
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [swsort_pkg::VALUE_W-1:0]    m_tdata,   // [31:0] sorted_value
    output logic                              m_tlast,   // last_result
    output logic                              m_tuser    // [0] overflowed
);
    import swsort_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic                 burst_ovf_reg, burst_ovf_next;
    logic                 dir_reg, dir_next;
    logic                 ascending_reg, ascending_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;
    logic                 m_tuser_reg, m_tuser_next;

    logic                 in_xfer;
    logic                 full;
    logic                 out_free;
    logic                 emit_now;
    logic                 last_one;
    cell_op_t             op;
    cell_link_t           bottom;
    cell_link_t           top;
    cell_link_t           emit_src;

    assign s_tready = (state_reg == ST_LOAD);
    assign in_xfer  = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign out_free = !m_tvalid_reg || m_tready;
    assign last_one = (count_reg == CNT_W'(1));

    // Ascending bursts leave from cell 0, descending ones from the top cell.
    assign emit_src = dir_reg ? bottom : top;
    assign emit_now = (state_reg == ST_EMIT) && out_free && emit_src.valid;

    always_comb begin
        op = OP_HOLD;
        if (in_xfer && !full) begin
            op = OP_INSERT;
        end else if ((state_reg == ST_EMIT) && out_free) begin
            op = dir_reg ? OP_SHIFT_DOWN : OP_SHIFT_UP;
        end
    end

    swsort_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .x       ($signed(s_tdata)),
        .bottom  (bottom),
        .top     (top)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        burst_ovf_next = burst_ovf_reg;
        dir_next       = dir_reg;
        ascending_next = cfg_wr_en ? cfg_wr_data : ascending_reg;
        m_tvalid_next  = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        m_tuser_next   = m_tuser_reg;

        if (in_xfer) begin
            if (full) begin
                dropped_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
            if (s_tlast) begin
                // The ascending bit and the drop flag are frozen for the burst.
                state_next     = ST_EMIT;
                dir_next       = ascending_reg;
                burst_ovf_next = dropped_reg || full;
                dropped_next   = 1'b0;
            end
        end

        if (emit_now) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = emit_src.value;
            m_tlast_next  = last_one;
            m_tuser_next  = burst_ovf_reg;
            count_next    = count_reg - CNT_W'(1);
            if (last_one) begin
                state_next = ST_LOAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            burst_ovf_reg <= 1'b0;
            dir_reg       <= 1'b1;
            ascending_reg <= 1'b1;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            burst_ovf_reg <= burst_ovf_next;
            dir_reg       <= dir_next;
            ascending_reg <= ascending_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // The element count never passes the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count exceeds capacity");

    // In an ascending burst cell 0 always holds a value while elements remain.
    a_asc_bottom: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && dir_reg && (count_reg != '0) |-> bottom.valid)
        else $error("ascending burst found cell 0 empty");

    // Handing out the last result returns the block to loading with a zero element count.
    a_burst_end: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_now && last_one |=> (state_reg == ST_LOAD) && (count_reg == '0))
        else $error("burst did not end cleanly");

    // A burst never starts from an empty set.
    a_burst_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_EMIT) |-> (count_reg != '0))
        else $error("burst started with no elements");
`endif

endmodule
